/* rtl/u8sd_pkg.sv */
package u8sd_pkg;

   localparam int unsigned MaxResults = 4;
   localparam int unsigned UnitWidth  = 21;

   localparam logic [20:0] ReplacementCp = 21'h00FFFD;
   localparam logic [20:0] SuppBase      = 21'h010000;
   localparam logic [20:0] HighSurrBase  = 21'h00D800;
   localparam logic [20:0] LowSurrBase   = 21'h00DC00;
   localparam logic [20:0] BmpMax        = 21'h00FFFF;

   localparam logic [1:0] ContTag  = 2'b10;
   localparam logic [2:0] Lead2Tag = 3'h6;
   localparam logic [3:0] Lead3Tag = 4'hE;
   localparam logic [4:0] Lead4Tag = 5'h1E;

   localparam logic [2:0] LenNone = 3'd0;
   localparam logic [2:0] Len2    = 3'd2;
   localparam logic [2:0] Len3    = 3'd3;
   localparam logic [2:0] Len4    = 3'd4;

   // sequence collected so far
   typedef struct packed {
      logic [2:0]  seq_length;
      logic [1:0]  cont_taken;
      logic [20:0] partial_point;
   } seq_state_type;

   // results caused by one byte, in order
   typedef struct packed {
      logic [MaxResults-1:0][UnitWidth-1:0] unit;
      logic [MaxResults-1:0]                rep;
      logic [2:0]                           count;
   } batch_type;

   // append one result, drop anything beyond the list
   function automatic batch_type push_unit(batch_type bt, logic [20:0] u, logic r);
      batch_type res;
      res = bt;
      if (bt.count < 3'(MaxResults)) begin
         res.unit[bt.count[1:0]] = u;
         res.rep[bt.count[1:0]]  = r;
         res.count               = bt.count + 3'd1;
      end
      return res;
   endfunction

   // whole code point, or a surrogate pair for one above U+FFFF in narrow mode
   function automatic batch_type push_point(batch_type bt, logic [20:0] cp, logic wide);
      batch_type   res;
      logic [20:0] v;
      v = cp - SuppBase;
      if (!wide && cp > BmpMax) begin
         res = push_unit(bt, HighSurrBase + {10'd0, v[20:10]}, 1'b0);
         res = push_unit(res, LowSurrBase + {11'd0, v[9:0]}, 1'b0);
      end else begin
         res = push_unit(bt, cp, 1'b0);
      end
      return res;
   endfunction

endpackage

/* rtl/u8sd_req_if.sv */
interface u8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

/* rtl/u8sd_rsp_if.sv */
interface u8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_unit;
   logic        is_replacement;
   logic        run_last;
   logic        string_done;

   modport source (output valid, output code_unit, output is_replacement,
                   output run_last, output string_done, input ready);
   modport sink (input valid, input code_unit, input is_replacement,
                 input run_last, input string_done, output ready);
endinterface

/* rtl/u8sd_step.sv */
module u8sd_step
   import u8sd_pkg::*;
(
   input  seq_state_type state_cur,
   input  logic [7:0]    in_byte,
   input  logic          end_of_string,
   input  logic          wide_units,
   output seq_state_type state_nxt,
   output batch_type     batch
);

   always_comb begin
      seq_state_type st;
      batch_type     bt;
      logic          consumed;
      logic [2:0]    taken_plus;

      st         = state_cur;
      bt         = '0;
      consumed   = 1'b0;
      taken_plus = 3'd0;

      if (st.seq_length != LenNone) begin
         if (in_byte[7:6] == ContTag) begin
            st.partial_point = {st.partial_point[14:0], in_byte[5:0]};
            st.cont_taken    = st.cont_taken + 2'd1;
            taken_plus       = {1'b0, st.cont_taken} + 3'd1;
            if (taken_plus >= st.seq_length) begin
               bt = push_point(bt, st.partial_point, wide_units);
               st = '0;
            end
            consumed = 1'b1;
         end else begin
            // abandon the sequence: one replacement per byte taken
            for (int k = 0; k < MaxResults; k++) begin
               if (k <= int'(st.cont_taken)) begin
                  bt = push_unit(bt, ReplacementCp, 1'b1);
               end
            end
            st = '0;
         end
      end

      if (!consumed) begin
         if (!in_byte[7]) begin
            bt = push_point(bt, {13'd0, in_byte}, wide_units);
         end else if (in_byte[7:5] == Lead2Tag) begin
            st = '{seq_length: Len2, cont_taken: 2'd0, partial_point: {16'd0, in_byte[4:0]}};
         end else if (in_byte[7:4] == Lead3Tag) begin
            st = '{seq_length: Len3, cont_taken: 2'd0, partial_point: {17'd0, in_byte[3:0]}};
         end else if (in_byte[7:3] == Lead4Tag) begin
            st = '{seq_length: Len4, cont_taken: 2'd0, partial_point: {18'd0, in_byte[2:0]}};
         end else begin
            bt = push_unit(bt, ReplacementCp, 1'b1);
         end
      end

      // truncated string
      if (end_of_string && st.seq_length != LenNone) begin
         for (int k = 0; k < MaxResults; k++) begin
            if (k <= int'(st.cont_taken)) begin
               bt = push_unit(bt, ReplacementCp, 1'b1);
            end
         end
         st = '0;
      end

      state_nxt = st;
      batch     = bt;
   end

endmodule

/* rtl/utf8_stream_decoder.sv */
// UTF-8 stream decoder: at most one byte is taken per cycle on req_ch and its code units
// (zero to four) leave on rsp_ch one per cycle, with malformed input replaced by U+FFFD
// (is_replacement set). A byte is decoded in the cycle it is accepted; its results sit in a
// four-entry result register that drains at one transfer per cycle, and the next byte is
// taken in the cycle the last pending result leaves, so the rate is one byte per cycle while
// each byte gives at most one unit and rsp_ch is ready; a byte with more units holds the next
// back until all have left. csr_wr_data written with csr_wr_en selects whole code points (1,
// the reset value) or UTF-16 surrogate pairs (0); write it only while no results are pending.
module utf8_stream_decoder
   import u8sd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   u8sd_req_if.sink   req_ch,
   u8sd_rsp_if.source rsp_ch
);

   logic          wide_ff;
   seq_state_type seq_ff;
   seq_state_type seq_in;
   batch_type     batch_in;

   logic [MaxResults-1:0][UnitWidth-1:0] unit_ff;
   logic [MaxResults-1:0]                rep_ff;
   logic [2:0]                           rem_ff;
   logic                                 eos_ff;

   logic accept;
   logic drain;

   u8sd_step u_step (
      .state_cur     (seq_ff),
      .in_byte       (req_ch.in_byte),
      .end_of_string (req_ch.end_of_string),
      .wide_units    (wide_ff),
      .state_nxt     (seq_in),
      .batch         (batch_in)
   );

   assign drain         = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready  = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_ch.ready);
   assign accept        = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid          = rem_ff != 3'd0;
   assign rsp_ch.code_unit      = unit_ff[0];
   assign rsp_ch.is_replacement = rep_ff[0];
   assign rsp_ch.run_last       = rem_ff == 3'd1;
   assign rsp_ch.string_done    = (rem_ff == 3'd1) && eos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b1;
      end else if (csr_wr_en) begin
         wide_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else if (accept) begin
         seq_ff <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
      end else if (accept) begin
         rem_ff <= batch_in.count;
      end else if (drain) begin
         rem_ff <= rem_ff - 3'd1;
      end
   end

   // result list: load on accept, advance by one on each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         unit_ff <= batch_in.unit;
         rep_ff  <= batch_in.rep;
         eos_ff  <= req_ch.end_of_string;
      end else if (drain) begin
         for (int k = 0; k < MaxResults - 1; k++) begin
            unit_ff[k] <= unit_ff[k+1];
            rep_ff[k]  <= rep_ff[k+1];
         end
      end
   end

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'(MaxResults))
      else $error("result count beyond list depth");

   a_eos_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.end_of_string |=> rem_ff != 3'd0)
      else $error("final byte of a string gave no result");

   a_eos_clears_seq: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.end_of_string |=> seq_ff.seq_length == LenNone)
      else $error("sequence left pending after end of string");

   a_seq_len_legal: assert property (@(posedge clock) disable iff (reset)
      seq_ff.seq_length == LenNone || seq_ff.seq_length == Len2 ||
      seq_ff.seq_length == Len3 || seq_ff.seq_length == Len4)
      else $error("illegal pending sequence length");
`endif

endmodule

/* tb/utf8_decode_checker.sv */
module utf8_decode_checker
   import u8sd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   u8sd_req_if  req_ch,
   u8sd_rsp_if  rsp_ch,
   output int   mismatches,
   output int   units_pending,
   output int   units_checked,
   output int   replacements_seen
);

   typedef struct packed {
      logic [20:0] code_unit;
      logic        is_replacement;
      logic        run_last;
      logic        string_done;
   } unit_entry_type;

   unit_entry_type expected_units[$];
   logic           wide_mode;
   logic [2:0]     seq_len;
   logic [1:0]     conts_taken;
   logic [20:0]    partial_cp;
   int             units_this_byte;

   task automatic report_mismatch(input string why, input unit_entry_type got,
                                  input unit_entry_type want);
      $display("unit %0d %s: got %06h/%0b/%0b/%0b, want %06h/%0b/%0b/%0b",
               units_checked, why, got.code_unit, got.is_replacement, got.run_last,
               got.string_done, want.code_unit, want.is_replacement, want.run_last,
               want.string_done);
      mismatches++;
   endtask

   // never more than four units per byte
   task automatic push_unit(input logic [20:0] u, input logic rep);
      if (units_this_byte < MaxResults) begin
         expected_units.insert(expected_units.size(), {u, rep, 1'b0, 1'b0});
         units_this_byte++;
      end
   endtask

   task automatic push_point(input logic [20:0] cp);
      logic [20:0] v;
      v = cp - SuppBase;
      if (!wide_mode && cp > BmpMax) begin
         push_unit(HighSurrBase + {10'd0, v[20:10]}, 1'b0);
         push_unit(LowSurrBase + {11'd0, v[9:0]}, 1'b0);
      end else begin
         push_unit(cp, 1'b0);
      end
   endtask

   task automatic clear_seq();
      seq_len     = LenNone;
      conts_taken = 2'd0;
      partial_cp  = 21'd0;
   endtask

   // one replacement for the lead byte and one per continuation taken
   task automatic flush_seq();
      int k;
      for (k = 0; k <= int'(conts_taken); k++) push_unit(ReplacementCp, 1'b1);
      clear_seq();
   endtask

   task automatic start_byte(input logic [7:0] b);
      if (b[7] == 1'b0) begin
         push_point({13'd0, b});
      end else if (b[7:5] == Lead2Tag) begin
         partial_cp  = {16'd0, b[4:0]};
         seq_len     = Len2;
         conts_taken = 2'd0;
      end else if (b[7:4] == Lead3Tag) begin
         partial_cp  = {17'd0, b[3:0]};
         seq_len     = Len3;
         conts_taken = 2'd0;
      end else if (b[7:3] == Lead4Tag) begin
         partial_cp  = {18'd0, b[2:0]};
         seq_len     = Len4;
         conts_taken = 2'd0;
      end else begin
         push_unit(ReplacementCp, 1'b1);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eos);
      unit_entry_type tail;
      logic           used;
      units_this_byte = 0;
      used            = 1'b0;
      if (seq_len != LenNone) begin
         if (b[7:6] == ContTag) begin
            partial_cp  = {partial_cp[14:0], b[5:0]};
            conts_taken = conts_taken + 2'd1;
            if (int'(conts_taken) + 1 >= int'(seq_len)) begin
               push_point(partial_cp);
               clear_seq();
            end
            used = 1'b1;
         end else begin
            flush_seq();
         end
      end
      // an offending byte is decoded afresh
      if (!used) start_byte(b);
      if (eos && seq_len != LenNone) flush_seq();
      if (units_this_byte > 0) begin
         tail             = expected_units.pop_back();
         tail.run_last    = 1'b1;
         tail.string_done = eos;
         expected_units.insert(expected_units.size(), tail);
      end
   endtask

   always @(posedge clock) begin
      unit_entry_type seen;
      unit_entry_type want;
      if (reset) begin
         wide_mode = 1'b1;
         clear_seq();
         expected_units.delete();
         mismatches        = 0;
         units_checked     = 0;
         replacements_seen = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.code_unit, rsp_ch.is_replacement, rsp_ch.run_last,
                    rsp_ch.string_done};
            if (expected_units.size() == 0) begin
               report_mismatch("with nothing expected", seen, '0);
            end else begin
               want = expected_units.pop_front();
               if (seen.code_unit != want.code_unit
                   || seen.is_replacement != want.is_replacement
                   || seen.run_last != want.run_last
                   || seen.string_done != want.string_done) begin
                  report_mismatch("differs", seen, want);
               end
            end
            units_checked++;
            if (seen.is_replacement) replacements_seen++;
         end
         if (req_ch.valid && req_ch.ready) decode_byte(req_ch.in_byte, req_ch.end_of_string);
         // a register write applies from the next byte on
         if (csr_wr_en) wide_mode = csr_wr_data;
      end
      units_pending = expected_units.size();
   end

endmodule

/* tb/tb_utf8_stream_decoder.sv */
module tb_utf8_stream_decoder;
   import u8sd_pkg::*;

   localparam int CycleLimit   = 200000;
   localparam int SettleCycles = 8;
   localparam int HoldCycles   = 60;
   localparam int HalfBytes    = 75;

   logic clock       = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   u8sd_req_if req_ch();
   u8sd_rsp_if rsp_ch();

   int mismatches;
   int units_pending;
   int units_checked;
   int replacements_seen;

   int cycles       = 0;
   int bytes_sent   = 0;
   int strings_sent = 0;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int rx_hold      = 0;

   logic [7:0] string_bytes[$];

   always #1 clock = ~clock;

   utf8_stream_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   utf8_decode_checker u_decode_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .mismatches        (mismatches),
      .units_pending     (units_pending),
      .units_checked     (units_checked),
      .replacements_seen (replacements_seen)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d units still expected", cycles, units_pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.in_byte       <= b;
      req_ch.end_of_string <= eos;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   task automatic send_string();
      int i;
      for (i = 0; i < string_bytes.size(); i++) begin
         send_byte(string_bytes[i], i == string_bytes.size() - 1);
      end
      string_bytes.delete();
      strings_sent++;
   endtask

   task automatic append_byte(input logic [7:0] b);
      string_bytes.insert(string_bytes.size(), b);
   endtask

   // lead byte for a sequence of seq_bytes, followed by nbytes-1 continuations
   task automatic add_encoded(input int seq_bytes, input int nbytes);
      int i;
      case (seq_bytes)
         1: append_byte({1'b0, 7'($urandom)});
         2: append_byte({Lead2Tag, 5'($urandom)});
         3: append_byte({Lead3Tag, 4'($urandom)});
         default: append_byte({Lead4Tag, 3'($urandom)});
      endcase
      for (i = 1; i < nbytes; i++) append_byte({ContTag, 6'($urandom)});
   endtask

   task automatic add_char();
      int pick;
      int seq_bytes;
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
         seq_bytes = $urandom_range(4, 1);
         add_encoded(seq_bytes, seq_bytes);
      end else if (pick < 80) begin
         append_byte(8'($urandom));
      end else if (pick < 90) begin
         seq_bytes = $urandom_range(4, 2);
         add_encoded(seq_bytes, $urandom_range(seq_bytes - 1, 1));
      end else if (pick < 95) begin
         append_byte({ContTag, 6'($urandom)});
      end else begin
         append_byte(8'($urandom_range(255, 248)));
      end
   endtask

   task automatic random_strings(input int nbytes_target);
      int first_byte;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < nbytes_target) begin
         repeat ($urandom_range(8, 1)) add_char();
         send_string();
      end
   endtask

   // hold the sender until every unit is back, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (units_pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_wide(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= 1'b0;
      req_ch.valid         <= 1'b0;
      req_ch.in_byte       <= 8'h00;
      req_ch.end_of_string <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ASCII extremes, 2/3/4-byte forms, a proper U+FFFD, stray continuation, bad lead,
      // missing continuation, lead cut by lead, top of the 21-bit range, truncated end
      string_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBD, 8'h80, 8'hFF,
                       8'hF0, 8'h9F, 8'h41, 8'hE2, 8'hC3, 8'hA9, 8'hF7, 8'hBF, 8'hBF,
                       8'hBF, 8'hF4, 8'h8F};
      send_string();
      drain();

      // surrogate pairs, lowest supplementary value and top of the 21-bit range
      write_wide(1'b0);
      string_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80};
      send_string();
      string_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_string();
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 29; rx_idle_pct = 74; end
            1: begin tx_idle_pct = 74; rx_idle_pct = 29; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int half = 0; half < 2; half++) begin
            write_wide(half == 0);
            // stall the receiver while bytes keep coming so the block backs up
            if (half == 0) rx_hold = HoldCycles;
            random_strings(HalfBytes);
            drain();
         end
      end

      $display("%0d bytes in %0d strings decoded in both unit widths under varied stalls",
               bytes_sent, strings_sent);
      $display("%0d code units checked, %0d of them replacements",
               units_checked, replacements_seen);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
